// ===== rtl/cross_stencil_star_detect_core_defines.svh =====
// Assertion macros shared by the checker of the star detector.
`ifndef CROSS_STENCIL_STAR_DETECT_CORE_DEFINES_SVH
`define CROSS_STENCIL_STAR_DETECT_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define CSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define CSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csd_pkg.sv =====
`timescale 1ns / 1ps
// Package: constants, register codes and the stage record of the star detector.
package csd_pkg;

    // Default frame limits.
    localparam int CSD_MAX_COLS = 1024;
    localparam int CSD_MAX_ROWS = 4096;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 11;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 11;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [SUM_W-1:0] t_sum;

    localparam t_sum THRESH_RESET = 11'd30;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS      = 2'd0,
        CFG_NUM_COLS      = 2'd1,
        CFG_SUM_THRESHOLD = 2'd2
    } t_cfg_reg;

    // Result slots of one item, in output order.
    localparam int NUM_SLOTS   = 3;
    localparam int SLOT_UPPER  = 0;  // pixel one row up, same column
    localparam int SLOT_PREV   = 1;  // last row, previous column
    localparam int SLOT_FINAL  = 2;  // last pixel of the frame

    // Operands of one item, already masked at the image border.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_vld;
        t_pix                 x;
        t_pix                 a_up;
        t_pix                 a_ctr;
        t_pix                 a_left;
        t_pix                 a_right;
        t_pix                 b_up;
        t_pix                 b_mid;
        t_pix                 b_left;
        t_pix                 c_up;
        t_pix                 c_left;
    } t_stage;

endpackage

// ===== rtl/csd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module csd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port returns the old data on a same-address write.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/csd_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers of the star detector, with row and column clamping.
module csd_cfg
    import csd_pkg::*;
#(
    parameter int MAX_COLS = CSD_MAX_COLS,
    parameter int MAX_ROWS = CSD_MAX_ROWS,
    localparam int RNUM_W  = $clog2(MAX_ROWS + 1),
    localparam int CNUM_W  = $clog2(MAX_COLS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [RNUM_W-1:0]     o_rows_eff,
    output logic [CNUM_W-1:0]     o_cols_eff,
    output t_sum                  o_threshold,
    output logic                  o_cfg_hold
);

    logic [RNUM_W-1:0] r_rows, n_rows, rows_new;
    logic [CNUM_W-1:0] r_cols, n_cols, cols_new;
    t_sum              r_thr, n_thr;
    logic              r_hold;
    logic [31:0]       v_rows, v_cols;

    // Zero acts as one, anything above the limit acts as the limit.
    always_comb begin
        v_rows = 32'(i_cfg_data[ROWS_CFG_W-1:0]);
        v_cols = 32'(i_cfg_data[COLS_CFG_W-1:0]);
        if (v_rows == 32'd0) begin
            rows_new = RNUM_W'(1);
        end else if (v_rows > 32'(MAX_ROWS)) begin
            rows_new = RNUM_W'(MAX_ROWS);
        end else begin
            rows_new = RNUM_W'(v_rows);
        end
        if (v_cols == 32'd0) begin
            cols_new = CNUM_W'(1);
        end else if (v_cols > 32'(MAX_COLS)) begin
            cols_new = CNUM_W'(MAX_COLS);
        end else begin
            cols_new = CNUM_W'(v_cols);
        end
    end

    // Register write decode.
    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        n_thr  = r_thr;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_NUM_ROWS: begin
                    n_rows = rows_new;
                end
                CFG_NUM_COLS: begin
                    n_cols = cols_new;
                end
                CFG_SUM_THRESHOLD: begin
                    n_thr = i_cfg_data[SUM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The hold flag covers the read-ahead of the line buffers after reset
    // and after any write, since the geometry may have moved the position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RNUM_W'(1);
            r_cols <= CNUM_W'(1);
            r_thr  <= THRESH_RESET;
            r_hold <= 1'b1;
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
            r_thr  <= n_thr;
            r_hold <= i_cfg_we;
        end
    end

    assign o_rows_eff  = r_rows;
    assign o_cols_eff  = r_cols;
    assign o_threshold = r_thr;
    assign o_cfg_hold  = r_hold || i_cfg_we;

endmodule

// ===== rtl/csd_front.sv =====
`timescale 1ns / 1ps
// Raster position, line buffers and the input register of the star detector.
module csd_front
    import csd_pkg::*;
#(
    parameter int MAX_COLS = CSD_MAX_COLS,
    parameter int MAX_ROWS = CSD_MAX_ROWS,
    localparam int RNUM_W  = $clog2(MAX_ROWS + 1),
    localparam int CNUM_W  = $clog2(MAX_COLS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_pix              i_pixel,
    input  logic [RNUM_W-1:0] i_rows_eff,
    input  logic [CNUM_W-1:0] i_cols_eff,
    input  logic              i_cfg_hold,
    output logic              o_s1_vld,
    output t_stage            o_s1,
    input  logic              i_s1_take
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [ROW_W-1:0]  r_row, pos_r, r_nxt;
    logic [COL_W-1:0]  r_col, pos_c, c_nxt, ctr_addr, right_addr;
    logic              restart, last_row, last_col;
    logic              row_ge1, row_ge2, col_ge1, col_ge2;
    logic              accept;
    t_pix              r_left, r_lrpp, r_px1, r_px2;
    t_pix              ram_c_q, ram_r_q, ram_a_q;
    t_pix              ctr, right_px, abv;
    logic              r_fwd_c, r_fwd_r, r_fwd_a, r_abv_ok, n_abv_ok;
    t_pix              r_fwd_x, r_fwd_a_d;
    logic [CNUM_W-1:0] r_fill, n_fill;
    logic              r_s1_vld;
    t_stage            r_s1, n_s1;

    // Current position; a position outside the geometry restarts the frame.
    always_comb begin
        restart  = (RNUM_W'(r_row) >= i_rows_eff) || (CNUM_W'(r_col) >= i_cols_eff);
        pos_r    = restart ? '0 : r_row;
        pos_c    = restart ? '0 : r_col;
        last_row = RNUM_W'(pos_r) == (i_rows_eff - RNUM_W'(1));
        last_col = CNUM_W'(pos_c) == (i_cols_eff - CNUM_W'(1));
        row_ge1  = pos_r != '0;
        row_ge2  = (pos_r != '0) && (pos_r != ROW_W'(1));
        col_ge1  = pos_c != '0;
        col_ge2  = (pos_c != '0) && (pos_c != COL_W'(1));
    end

    // Position after this item.
    always_comb begin
        if (last_col) begin
            c_nxt = '0;
            r_nxt = last_row ? '0 : pos_r + ROW_W'(1);
        end else begin
            c_nxt = pos_c + COL_W'(1);
            r_nxt = pos_r;
        end
    end

    assign o_in_ready = (!r_s1_vld || i_s1_take) && !i_cfg_hold;
    assign accept     = i_in_valid && o_in_ready;

    // Buffers are read ahead at the position the next item will use.
    assign ctr_addr   = accept ? c_nxt : pos_c;
    assign right_addr = ctr_addr + COL_W'(1);

    // Newest row. Two copies give the centre and right taps in the same cycle.
    csd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_center_c (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (pos_c),
        .i_wdata (i_pixel),
        .i_raddr (ctr_addr),
        .o_rdata (ram_c_q)
    );

    csd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_center_r (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (pos_c),
        .i_wdata (i_pixel),
        .i_raddr (right_addr),
        .o_rdata (ram_r_q)
    );

    // Row above the row whose results are being formed.
    csd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_above (
        .i_clk   (i_clk),
        .i_we    (accept && row_ge1),
        .i_waddr (pos_c),
        .i_wdata (ctr),
        .i_raddr (ctr_addr),
        .o_rdata (ram_a_q)
    );

    // A read that met a write to the same entry takes the written value.
    // Entries of the above row past the fill count have never been written
    // and read as zero.
    always_comb begin
        ctr      = r_fwd_c ? r_fwd_x : ram_c_q;
        right_px = r_fwd_r ? r_fwd_x : ram_r_q;
        if (r_fwd_a) begin
            abv = r_fwd_a_d;
        end else if (r_abv_ok) begin
            abv = ram_a_q;
        end else begin
            abv = '0;
        end
    end

    // The above row is always written from column zero upward.
    always_comb begin
        n_fill = r_fill;
        if (accept && row_ge1 && (CNUM_W'(pos_c) >= r_fill)) begin
            n_fill = CNUM_W'(pos_c) + CNUM_W'(1);
        end
        n_abv_ok = CNUM_W'(ctr_addr) < n_fill;
    end

    // Operands of the up to three results of this item, zeroed at the border.
    always_comb begin
        n_s1.slot_vld[SLOT_UPPER] = row_ge1;
        n_s1.slot_vld[SLOT_PREV]  = last_row && col_ge1;
        n_s1.slot_vld[SLOT_FINAL] = last_row && last_col;
        n_s1.x       = i_pixel;
        n_s1.a_up    = row_ge2 ? abv : '0;
        n_s1.a_ctr   = ctr;
        n_s1.a_left  = col_ge1 ? r_left : '0;
        n_s1.a_right = last_col ? '0 : right_px;
        n_s1.b_up    = row_ge1 ? r_left : '0;
        n_s1.b_mid   = r_lrpp;
        n_s1.b_left  = col_ge2 ? r_px2 : '0;
        n_s1.c_up    = row_ge1 ? ctr : '0;
        n_s1.c_left  = col_ge1 ? r_lrpp : '0;
    end

    // Control and position state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_left   <= '0;
            r_lrpp   <= '0;
            r_px1    <= '0;
            r_px2    <= '0;
            r_fwd_c  <= 1'b0;
            r_fwd_r  <= 1'b0;
            r_fwd_a  <= 1'b0;
            r_abv_ok <= 1'b0;
            r_fill   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_fwd_c  <= accept && (ctr_addr == pos_c);
            r_fwd_r  <= accept && (right_addr == pos_c);
            r_fwd_a  <= accept && row_ge1 && (ctr_addr == pos_c);
            r_abv_ok <= n_abv_ok;
            r_fill   <= n_fill;
            if (accept) begin
                r_row <= r_nxt;
                r_col <= c_nxt;
                r_px1 <= i_pixel;
                r_px2 <= r_px1;
                if (row_ge1) begin
                    r_left <= ctr;
                end
                if (last_row) begin
                    r_lrpp <= i_pixel;
                end
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (i_s1_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_fwd_x   <= i_pixel;
        r_fwd_a_d <= ctr;
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_vld = r_s1_vld;
    assign o_s1     = r_s1;

endmodule

// ===== rtl/csd_result.sv =====
`timescale 1ns / 1ps
// Stencil sums, threshold compare and the result register of the star detector.
module csd_result
    import csd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_sum   i_threshold,
    input  logic   i_s1_vld,
    input  t_stage i_s1,
    output logic   o_s1_take,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output logic   o_is_star,
    output logic   o_last_of_run,
    output logic   o_end_of_frame
);

    t_sum                 sum_a, sum_b, sum_c;
    logic [NUM_SLOTS-1:0] star, r_star;
    logic [NUM_SLOTS-1:0] r_mask, n_mask, head_oh, rest;
    logic                 pop, can_load, load;

    // Five-point sums; border operands arrive as zero.
    always_comb begin
        sum_a = t_sum'(i_s1.a_up) + t_sum'(i_s1.a_ctr) + t_sum'(i_s1.x)
              + t_sum'(i_s1.a_left) + t_sum'(i_s1.a_right);
        sum_b = t_sum'(i_s1.b_up) + t_sum'(i_s1.b_mid) + t_sum'(i_s1.x)
              + t_sum'(i_s1.b_left);
        sum_c = t_sum'(i_s1.c_up) + t_sum'(i_s1.x) + t_sum'(i_s1.c_left);
        star[SLOT_UPPER] = sum_a > i_threshold;
        star[SLOT_PREV]  = sum_b > i_threshold;
        star[SLOT_FINAL] = sum_c > i_threshold;
    end

    // The lowest pending slot is shown first.
    always_comb begin
        head_oh        = r_mask & (~r_mask + NUM_SLOTS'(1));
        rest           = r_mask & ~head_oh;
        o_out_valid    = |r_mask;
        o_is_star      = |(head_oh & r_star);
        o_last_of_run  = rest == '0;
        o_end_of_frame = head_oh[SLOT_FINAL];
    end

    // A new item loads once the last pending result leaves.
    always_comb begin
        pop       = o_out_valid && i_out_ready;
        can_load  = !o_out_valid || (pop && (rest == '0));
        o_s1_take = i_s1_vld && ((i_s1.slot_vld == '0) || can_load);
        load      = o_s1_take && (i_s1.slot_vld != '0);
        priority if (load) begin
            n_mask = i_s1.slot_vld;
        end else if (pop) begin
            n_mask = rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_star <= star;
        end
    end

endmodule

// ===== rtl/cross_stencil_star_detect_core.sv =====
`timescale 1ns / 1ps
// Top level of the five-point cross stencil star detector.
//
//  Channel  Signals                               Direction  Moves
//  input    i_in_valid / o_in_ready / i_pixel     in         one pixel, raster order
//  output   o_out_valid / i_out_ready / flags     out        one map result
//  config   i_cfg_we / i_cfg_idx / i_cfg_data     in         one register write
//
// One pixel per clock unless the output stalls; in the last row of a frame a
// pixel can give up to two results and the frame's last pixel up to three, so
// there the single result register sets the pace at one result per clock.
// Items pass from the input register through the sums into the result register.
// Reset is synchronous, active low; the input stays stalled after reset and
// after each configuration write while the line buffers read ahead. A stalled
// output holds its result and backs up the input.
module cross_stencil_star_detect_core
    import csd_pkg::*;
#(
    parameter int MAX_COLS = CSD_MAX_COLS,
    parameter int MAX_ROWS = CSD_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pix                  i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_is_star,
    output logic                  o_last_of_run,
    output logic                  o_end_of_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RNUM_W = $clog2(MAX_ROWS + 1);
    localparam int CNUM_W = $clog2(MAX_COLS + 1);

    logic [RNUM_W-1:0] rows_eff;
    logic [CNUM_W-1:0] cols_eff;
    t_sum              threshold;
    logic              cfg_hold;
    logic              s1_vld, s1_take;
    t_stage            s1;

    // Configuration registers.
    csd_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_rows_eff  (rows_eff),
        .o_cols_eff  (cols_eff),
        .o_threshold (threshold),
        .o_cfg_hold  (cfg_hold)
    );

    // Position tracking, line buffers and input register.
    csd_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel    (i_pixel),
        .i_rows_eff (rows_eff),
        .i_cols_eff (cols_eff),
        .i_cfg_hold (cfg_hold),
        .o_s1_vld   (s1_vld),
        .o_s1       (s1),
        .i_s1_take  (s1_take)
    );

    // Sums, compares and result register.
    csd_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold    (threshold),
        .i_s1_vld       (s1_vld),
        .i_s1           (s1),
        .o_s1_take      (s1_take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_is_star      (o_is_star),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

// ===== rtl/csd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the star detector and its bind to the top level.
`include "cross_stencil_star_detect_core_defines.svh"

module csd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_cfg_we,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_is_star,
    input logic i_last_of_run,
    input logic i_end_of_frame
);

    // A result that is not taken stays offered.
    `CSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result withdrawn while stalled")

    // A stalled result keeps its flags.
    `CSD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_is_star) && $stable(i_last_of_run) && $stable(i_end_of_frame), "result changed while stalled")

    // The frame's last result is always the last one of its item.
    `CSD_ASSERT_NOW(a_eof_last, i_clk, i_rst_n, i_out_valid && i_end_of_frame, i_last_of_run, "end of frame without last of run")

    // The line buffers re-read after a register write before a pixel is taken.
    `CSD_ASSERT_NEXT(a_cfg_stall, i_clk, i_rst_n, i_cfg_we, !i_in_ready, "pixel taken right after a register write")

endmodule

bind cross_stencil_star_detect_core csd_checker u_csd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (o_in_ready),
    .i_cfg_we       (i_cfg_we),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_is_star      (o_is_star),
    .i_last_of_run  (o_last_of_run),
    .i_end_of_frame (o_end_of_frame)
);

// ===== test/tb_cross_stencil_star_detect_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the five-point cross stencil star detector.
module tb_cross_stencil_star_detect_core;
    import csd_pkg::*;

    localparam int IDLE_PCT     = 12;
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_LIMIT  = 20000;

    // Intensity profiles used to fill a frame.
    typedef enum int {
        MODE_FULL_RANGE,
        MODE_DIM,
        MODE_BLACK_WHITE
    } t_pixel_mode;

    // Flags of one map pixel as the block should report them.
    typedef struct packed {
        logic is_star;
        logic last_of_run;
        logic end_of_frame;
    } t_star_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    t_pix                  i_pixel        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_is_star;
    logic                  o_last_of_run;
    logic                  o_end_of_frame;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = CFG_NUM_ROWS;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Shadow of the block: line stores, scan position and registers.
    t_pix above_line  [CSD_MAX_COLS];
    t_pix center_line [CSD_MAX_COLS];
    int   row_pos;
    int   col_pos;
    t_pix last_prev_pixel;
    t_pix left_ctr;
    int   model_rows;
    int   model_cols;
    int   model_thresh;

    t_star_result star_results_due [$];
    int           error_count    = 0;
    int           pixels_sent    = 0;
    int           results_seen   = 0;
    bit           no_idle        = 1'b0;

    cross_stencil_star_detect_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_is_star      (o_is_star),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // A size of zero acts as one, and anything above the maximum as the maximum.
    function automatic int clamp_size(input int value, input int max_size);
        if (value == 0) return 1;
        if (value > max_size) return max_size;
        return value;
    endfunction

    // Works out the flags caused by one accepted pixel and queues them.
    function automatic void predict_star_flags(input t_pix x);
        int           rows_eff;
        int           cols_eff;
        int           r;
        int           c;
        int           sum;
        int           n;
        t_pix         ctr;
        t_star_result res [NUM_SLOTS];
        rows_eff = clamp_size(model_rows, CSD_MAX_ROWS);
        cols_eff = clamp_size(model_cols, CSD_MAX_COLS);
        n = 0;
        if (row_pos >= rows_eff || col_pos >= cols_eff) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;

        // The new pixel completes the cross of the pixel one row up.
        if (r >= 1) begin
            ctr = center_line[c];
            sum = int'(ctr) + int'(x);
            if (r >= 2) sum += int'(above_line[c]);
            if (c > 0) sum += int'(left_ctr);
            if (c + 1 < cols_eff) sum += int'(center_line[c + 1]);
            res[n] = '{is_star: (sum > model_thresh), last_of_run: 1'b0,
                       end_of_frame: 1'b0};
            n++;
            left_ctr      = ctr;
            above_line[c] = ctr;
        end
        center_line[c] = x;

        // In the last row there is no lower neighbor, so results also flow
        // for the previous column and for the frame's final pixel.
        if (r == rows_eff - 1) begin
            if (c >= 1) begin
                sum = int'(last_prev_pixel) + int'(x);
                if (r >= 1) sum += int'(above_line[c - 1]);
                if (c >= 2) sum += int'(center_line[c - 2]);
                res[n] = '{is_star: (sum > model_thresh), last_of_run: 1'b0,
                           end_of_frame: 1'b0};
                n++;
            end
            if (c == cols_eff - 1) begin
                sum = int'(x);
                if (r >= 1) sum += int'(above_line[c]);
                if (c >= 1) sum += int'(last_prev_pixel);
                res[n] = '{is_star: (sum > model_thresh), last_of_run: 1'b0,
                           end_of_frame: 1'b1};
                n++;
            end
            last_prev_pixel = x;
        end

        if (n > 0) res[n - 1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++) star_results_due.push_back(res[k]);

        c++;
        if (c >= cols_eff) begin
            c = 0;
            r++;
            if (r >= rows_eff) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function automatic t_pix pick_pixel(input t_pixel_mode mode);
        case (mode)
            MODE_FULL_RANGE: return t_pix'($urandom_range(255));
            MODE_DIM:        return t_pix'($urandom_range(15));
            default:         return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // Thresholds near the typical five-pixel sum of each profile.
    function automatic int pick_threshold(input t_pixel_mode mode);
        case (mode)
            MODE_FULL_RANGE: return $urandom_range(880, 400);
            MODE_DIM:        return $urandom_range(50, 15);
            default: begin
                case ($urandom_range(7))
                    0:       return 0;
                    1:       return 1275;
                    default: return $urandom_range(1275);
                endcase
            end
        endcase
    endfunction

    // One register write; the block takes it at the next rising edge.
    task automatic write_reg(input t_cfg_reg idx, input int value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_NUM_ROWS:      model_rows   = value;
            CFG_NUM_COLS:      model_cols   = value;
            CFG_SUM_THRESHOLD: model_thresh = value;
            default: ;
        endcase
    endtask

    // Offers one pixel and returns after it is accepted, valid still high.
    task automatic send_pixel(input t_pix value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel    = value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_star_flags(value);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Stops the input and waits until every expected result has come back.
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_in_valid = 1'b0;
        while (star_results_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        if (star_results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, star_results_due.size());
            error_count++;
            star_results_due.delete();
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Programs a geometry and sends a frame, or only its first cut pixels.
    task automatic send_frame(input int rows, input int cols, input int thresh,
                              input t_pixel_mode mode, input int cut);
        int count;
        write_reg(CFG_NUM_ROWS, rows);
        write_reg(CFG_NUM_COLS, cols);
        write_reg(CFG_SUM_THRESHOLD, thresh);
        count = clamp_size(rows, CSD_MAX_ROWS) * clamp_size(cols, CSD_MAX_COLS);
        if (cut != 0) count = cut;
        repeat (count) send_pixel(pick_pixel(mode));
        wait_idle();
    endtask

    // Registers at their reset values: each pixel is a frame of its own.
    task automatic test_reset_geometry();
        send_pixel(8'd30);
        send_pixel(8'd31);
        send_pixel(8'd255);
        wait_idle();
    endtask

    // Zero rows and columns act as a single pixel; threshold at its floor.
    task automatic test_zero_sizes();
        write_reg(CFG_NUM_ROWS, 0);
        write_reg(CFG_NUM_COLS, 0);
        write_reg(CFG_SUM_THRESHOLD, 0);
        send_pixel(8'd0);
        send_pixel(8'd1);
        wait_idle();
    endtask

    // Saturated 3x3 image: only the center reaches the full sum of 1275.
    task automatic test_full_scale_center();
        write_reg(CFG_NUM_ROWS, 3);
        write_reg(CFG_NUM_COLS, 3);
        write_reg(CFG_SUM_THRESHOLD, 1274);
        repeat (9) send_pixel(8'd255);
        wait_idle();
    endtask

    // One row: every result comes from the last-row flush path.
    task automatic test_single_row();
        write_reg(CFG_NUM_ROWS, 1);
        write_reg(CFG_NUM_COLS, 4);
        write_reg(CFG_SUM_THRESHOLD, 0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd128);
        wait_idle();
    endtask

    // One column with the top threshold: nothing can be a star.
    task automatic test_single_column();
        write_reg(CFG_NUM_ROWS, 4);
        write_reg(CFG_NUM_COLS, 1);
        write_reg(CFG_SUM_THRESHOLD, 1275);
        repeat (4) send_pixel(8'd255);
        wait_idle();
    endtask

    // Shrinking the frame under the scan position restarts it at the origin.
    task automatic test_restart_mid_frame();
        write_reg(CFG_NUM_ROWS, 3);
        write_reg(CFG_NUM_COLS, 2);
        write_reg(CFG_SUM_THRESHOLD, 30);
        send_pixel(8'd10);
        send_pixel(8'd20);
        send_pixel(8'd7);
        wait_idle();
        write_reg(CFG_NUM_ROWS, 1);
        send_pixel(8'd12);
        send_pixel(8'd40);
        wait_idle();
    endtask

    // Small random frames; some are abandoned and the next one forces a restart.
    // The last frame is always complete, so the scan ends at the origin.
    task automatic test_random_frames();
        int          items;
        int          rows;
        int          cols;
        int          frame_px;
        int          cut;
        bit          restart_due;
        t_pixel_mode mode;
        items       = 0;
        restart_due = 1'b0;
        while (items < RANDOM_ITEMS) begin
            mode = t_pixel_mode'($urandom_range(2));
            rows = $urandom_range(6, 1);
            cols = $urandom_range(8, 1);
            if (restart_due) begin
                if (row_pos >= 1) rows = $urandom_range(row_pos, 1);
                else cols = $urandom_range(col_pos, 1);
            end
            frame_px = rows * cols;
            cut = 0;
            if (frame_px > 2 && items + frame_px < RANDOM_ITEMS && $urandom_range(7) == 0)
                cut = $urandom_range(frame_px - 1, 1);
            send_frame(rows, cols, pick_threshold(mode), mode, cut);
            items += (cut != 0) ? cut : frame_px;
            restart_due = (cut != 0);
        end
    endtask

    // A frame sent back to back with no idling, then clamped register values
    // on partial frames, each of which forces a restart of the next frame.
    task automatic test_max_geometry();
        no_idle = 1'b1;
        send_frame(5, 8, pick_threshold(MODE_FULL_RANGE), MODE_FULL_RANGE, 0);
        no_idle = 1'b0;
        send_frame(1, 2047, pick_threshold(MODE_BLACK_WHITE), MODE_BLACK_WHITE, 8);
        send_frame(CSD_MAX_ROWS, 2, pick_threshold(MODE_DIM), MODE_DIM, 7);
        send_frame(8191, 1, pick_threshold(MODE_DIM), MODE_DIM, 6);
        send_frame(2, 2, pick_threshold(MODE_FULL_RANGE), MODE_FULL_RANGE, 0);
    endtask

    // The output side stalls at random, except during the no-idle stretch.
    always @(negedge i_clk)
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    // Each accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_star_result due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (star_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got star %0b last %0b eof %0b",
                         $time, o_is_star, o_last_of_run, o_end_of_frame);
                error_count++;
            end else begin
                due = star_results_due.pop_front();
                if (o_is_star !== due.is_star) begin
                    $display("%0t: is_star mismatch, expected %0b, got %0b",
                             $time, due.is_star, o_is_star);
                    error_count++;
                end
                if (o_last_of_run !== due.last_of_run) begin
                    $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                             $time, due.last_of_run, o_last_of_run);
                    error_count++;
                end
                if (o_end_of_frame !== due.end_of_frame) begin
                    $display("%0t: end_of_frame mismatch, expected %0b, got %0b",
                             $time, due.end_of_frame, o_end_of_frame);
                    error_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        for (int k = 0; k < CSD_MAX_COLS; k++) begin
            above_line[k]  = '0;
            center_line[k] = '0;
        end
        row_pos         = 0;
        col_pos         = 0;
        last_prev_pixel = '0;
        left_ctr        = '0;
        model_rows      = 1;
        model_cols      = 1;
        model_thresh    = int'(THRESH_RESET);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_geometry();
        test_zero_sizes();
        test_full_scale_center();
        test_single_row();
        test_single_column();
        test_restart_mid_frame();
        test_random_frames();
        test_max_geometry();
        wait_idle();

        $display("Run covered %0d pixels and %0d results: single-pixel, one-row, one-column,",
                 pixels_sent, results_seen);
        $display("saturated, random, restarted and back-to-back frames with clamped sizes.");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("Run timed out with %0d results still due", star_results_due.size());
        $display("tb: failure");
        $finish;
    end

endmodule
